// ===== design/tlbptc_pkg.sv =====
// Shared types and constants for the TLB and page table translator.
`default_nettype none

package tlbptc_pkg;

  // Fixed field widths.
  localparam int unsigned PAGE_W   = 8;
  localparam int unsigned OFFSET_W = 8;
  localparam int unsigned FRAME_W  = 8;
  localparam int unsigned PADDR_W  = 16;
  localparam int unsigned OUTC_W   = 2;

  // Outcome codes.
  localparam logic [OUTC_W-1:0] OUT_TLB_HIT  = 2'd0;
  localparam logic [OUTC_W-1:0] OUT_PT_HIT   = 2'd1;
  localparam logic [OUTC_W-1:0] OUT_FAULT    = 2'd2;
  localparam logic [OUTC_W-1:0] OUT_NO_FRAME = 2'd3;

  // One input item.
  typedef struct packed {
    logic [PAGE_W-1:0]   page_number;
    logic [OFFSET_W-1:0] offset;
  } tlbptc_req_t;

  // One result item.
  typedef struct packed {
    logic [PADDR_W-1:0] physical_address;
    logic [FRAME_W-1:0] frame_number;
    logic [OUTC_W-1:0]  outcome;
  } tlbptc_rsp_t;

  // Fill command broadcast to the TLB cells.
  typedef struct packed {
    logic               fill;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } tlbptc_fill_t;

  // Lookup answer of one TLB cell; frame is zero unless the cell hits.
  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } tlbptc_cell_rsp_t;

  // Page table entry.
  typedef struct packed {
    logic               present;
    logic [FRAME_W-1:0] frame;
  } tlbptc_pte_t;

endpackage

`default_nettype wire

// ===== design/tlb_page_table_translator_core.sv =====
// Top level of the TLB and page table address translator.
//
// An item (page number and offset) is taken on a rising edge where start is
// high and busy is low. The next cycle searches the row of TLB cells and
// reads the page table word fetched at acceptance; a miss in both allocates
// the next free frame, if any is left. The result (physical address, frame,
// outcome) is registered from the lookup cycle and shown on rsp_o for
// exactly one cycle with rsp_valid_o high. busy is low again in that result
// cycle, so a new item may be started then; none is taken during the lookup
// cycle, due to the registered page table read ahead of the TLB decision.
// Frames are never released, so the lowest free frame is the count of
// frames handed out so far.
// After reset the page table present bits are cleared by a sweep over all
// PAGE_COUNT entries, one entry a cycle; busy stays high during the sweep.
// The receiver cannot stall: each result must be taken in its one cycle.
`default_nettype none

module tlb_page_table_translator_core
  import tlbptc_pkg::*;
#(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_COUNT  = 256,
  parameter int unsigned FRAME_COUNT = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire tlbptc_req_t req_i,
  output logic             rsp_valid_o,
  output tlbptc_rsp_t      rsp_o
);

  localparam int unsigned PG_W   = $clog2(PAGE_COUNT);
  localparam int unsigned FR_W   = $clog2(FRAME_COUNT + 1);
  localparam int unsigned LUT_N  = 2 ** PAGE_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e              state_q;
  logic [PAGE_W-1:0]   page_q;
  logic [OFFSET_W-1:0] offset_q;
  logic [PG_W-1:0]     pidx_q;
  logic [FR_W-1:0]     alloc_q;
  logic [FR_W-1:0]     alloc_d;
  tlbptc_rsp_t         rsp_q;
  tlbptc_rsp_t         rsp_d;
  logic                rsp_valid_q;

  logic                accept;
  logic [PG_W-1:0]     pidx_lut [LUT_N];
  tlbptc_pte_t         pte;
  tlbptc_pte_t         pte_wr;
  logic                pt_wr_en;
  logic                pt_ready;
  tlbptc_fill_t        fill;
  tlbptc_cell_rsp_t    cell_rsp [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tokens;
  logic                tlb_hit;
  logic [FRAME_W-1:0]  tlb_frame;
  logic                frames_full;
  logic [FRAME_W-1:0]  new_frame;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // Page index table: page number modulo the page table depth.
  for (genvar g = 0; g < LUT_N; g++) begin : g_pidx
    assign pidx_lut[g] = PG_W'(g % PAGE_COUNT);
  end

  // Page table, read at acceptance and written on a fault.
  tlbptc_page_table #(
    .PAGE_COUNT(PAGE_COUNT)
  ) u_pt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (pidx_lut[req_i.page_number]),
    .rd_data_o (pte),
    .wr_en_i   (pt_wr_en),
    .wr_addr_i (pidx_q),
    .wr_data_i (pte_wr),
    .ready_o   (pt_ready)
  );

  // Row of TLB cells; the fill token moves to the next cell on every fill.
  for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
    localparam int unsigned PREV = (i == 0) ? TLB_ENTRIES - 1 : i - 1;
    tlbptc_cell #(
      .INIT_TOKEN(i == 0)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .lookup_page_i (page_q),
      .fill_i        (fill),
      .token_i       (tokens[PREV]),
      .token_o       (tokens[i]),
      .rsp_o         (cell_rsp[i])
    );
  end

  // Gather the cell answers; at most one cell can hit.
  always_comb begin
    tlb_hit   = 1'b0;
    tlb_frame = '0;
    for (int k = 0; k < TLB_ENTRIES; k++) begin
      tlb_hit   = tlb_hit | cell_rsp[k].hit;
      tlb_frame = tlb_frame | cell_rsp[k].frame;
    end
  end

  assign frames_full = (alloc_q == FR_W'(FRAME_COUNT));
  assign new_frame   = FRAME_W'(alloc_q);

  // Translation decision in the lookup cycle.
  always_comb begin
    fill        = '0;
    fill.page   = page_q;
    pt_wr_en    = 1'b0;
    pte_wr      = '{present: 1'b1, frame: new_frame};
    alloc_d     = alloc_q;
    rsp_d       = '0;
    if (state_q == ST_LOOKUP) begin
      if (tlb_hit) begin
        rsp_d.frame_number = tlb_frame;
        rsp_d.outcome      = OUT_TLB_HIT;
      end else if (pte.present) begin
        rsp_d.frame_number = pte.frame;
        rsp_d.outcome      = OUT_PT_HIT;
        fill.fill          = 1'b1;
        fill.frame         = pte.frame;
      end else if (!frames_full) begin
        rsp_d.frame_number = new_frame;
        rsp_d.outcome      = OUT_FAULT;
        fill.fill          = 1'b1;
        fill.frame         = new_frame;
        pt_wr_en           = 1'b1;
        alloc_d            = alloc_q + 1'b1;
      end else begin
        rsp_d.outcome      = OUT_NO_FRAME;
      end
      if (rsp_d.outcome != OUT_NO_FRAME) begin
        rsp_d.physical_address = {rsp_d.frame_number, offset_q};
      end
    end
  end

  // State machine and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      page_q      <= '0;
      offset_q    <= '0;
      pidx_q      <= '0;
      alloc_q     <= '0;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          if (pt_ready) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            page_q   <= req_i.page_number;
            offset_q <= req_i.offset;
            pidx_q   <= pidx_lut[req_i.page_number];
            state_q  <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          alloc_q     <= alloc_d;
          rsp_q       <= rsp_d;
          rsp_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

`ifndef SYNTHESIS
  // Exactly one TLB cell holds the fill token at any time.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(tokens))
    else $error("TLB fill token is not one-hot");

  // A result appears only right after a lookup cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(state_q == ST_LOOKUP))
    else $error("Result without a preceding lookup");

  // An accepted item keeps the block busy for the lookup cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !rsp_valid_o))
    else $error("Block not busy after accepting an item");

  // The frame allocator never passes the number of frames.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc_q <= FR_W'(FRAME_COUNT))
    else $error("Frame allocator overflow");
`endif

endmodule

`default_nettype wire

// ===== design/tlbptc_cell.sv =====
// One TLB entry cell: holds a tag and a frame, and passes the fill token along the ring.
`default_nettype none

module tlbptc_cell
  import tlbptc_pkg::*;
#(
  parameter bit INIT_TOKEN = 1'b0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [PAGE_W-1:0] lookup_page_i,
  input  wire tlbptc_fill_t      fill_i,
  input  wire logic              token_i,
  output logic                   token_o,
  output tlbptc_cell_rsp_t       rsp_o
);

  logic               valid_q;
  logic [PAGE_W-1:0]  tag_q;
  logic [FRAME_W-1:0] frame_q;
  logic               token_q;

  // Control state: valid bit and fill token.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      token_q <= INIT_TOKEN;
    end else if (fill_i.fill) begin
      if (token_q) begin
        valid_q <= 1'b1;
      end
      token_q <= token_i;
    end
  end

  // Entry payload is loaded when this cell holds the token.
  always_ff @(posedge clk_i) begin
    if (fill_i.fill && token_q) begin
      tag_q   <= fill_i.page;
      frame_q <= fill_i.frame;
    end
  end

  // Local tag compare; the frame is masked so the row can be OR-reduced.
  always_comb begin
    rsp_o.hit   = valid_q && (tag_q == lookup_page_i);
    rsp_o.frame = rsp_o.hit ? frame_q : '0;
  end

  assign token_o = token_q;

endmodule

`default_nettype wire

// ===== design/tlbptc_page_table.sv =====
// Page table memory with a clearing pass of the present bits after reset.
`default_nettype none

module tlbptc_page_table
  import tlbptc_pkg::*;
#(
  parameter int unsigned PAGE_COUNT = 256,
  localparam int unsigned PG_W      = $clog2(PAGE_COUNT)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            rd_en_i,
  input  wire logic [PG_W-1:0] rd_addr_i,
  output tlbptc_pte_t          rd_data_o,
  input  wire logic            wr_en_i,
  input  wire logic [PG_W-1:0] wr_addr_i,
  input  wire tlbptc_pte_t     wr_data_i,
  output logic                 ready_o
);

  tlbptc_pte_t     mem [PAGE_COUNT];
  tlbptc_pte_t     rd_q;
  logic [PG_W-1:0] clr_q;
  logic            ready_q;
  logic            we;
  logic [PG_W-1:0] waddr;
  tlbptc_pte_t     wdata;

  // Clearing sweep: one entry per cycle until the last one is written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      ready_q <= 1'b0;
    end else if (!ready_q) begin
      if (clr_q == PG_W'(PAGE_COUNT - 1)) begin
        ready_q <= 1'b1;
      end else begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // The sweep owns the write port until it is done.
  always_comb begin
    we    = !ready_q || wr_en_i;
    waddr = ready_q ? wr_addr_i : clr_q;
    wdata = ready_q ? wr_data_i : '0;
  end

  // Single write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;
  assign ready_o   = ready_q;

endmodule

`default_nettype wire

// ===== verif/tlb_page_table_translator_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the TLB and page table address translator core.
module tlb_page_table_translator_core_tb;
  import tlbptc_pkg::*;

  localparam int unsigned TLB_SLOTS    = 16;
  localparam int unsigned PAGE_SLOTS   = 256;
  localparam int unsigned FRAME_SLOTS  = 256;
  localparam int unsigned RANDOM_ITEMS = 1830;
  localparam int unsigned MAX_GAP      = 6;
  localparam int unsigned RECENT_DEPTH = 12;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam longint unsigned CYCLE_LIMIT = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  tlbptc_req_t req_i;
  logic        rsp_valid_o;
  tlbptc_rsp_t rsp_o;

  tlb_page_table_translator_core #(
    .TLB_ENTRIES(TLB_SLOTS),
    .PAGE_COUNT (PAGE_SLOTS),
    .FRAME_COUNT(FRAME_SLOTS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  // Translation state as the block should hold it.
  logic [PAGE_W-1:0]  tlb_tag_q    [TLB_SLOTS];
  logic [FRAME_W-1:0] tlb_frame_q  [TLB_SLOTS];
  logic               tlb_valid_q  [TLB_SLOTS];
  int unsigned        tlb_next_slot;
  logic [FRAME_W-1:0] pt_frame_q   [PAGE_SLOTS];
  logic               pt_present_q [PAGE_SLOTS];
  logic               frame_taken_q[FRAME_SLOTS];

  // Translations still owed by the block, oldest first.
  tlbptc_rsp_t expected_translations[$];

  // Page history used to steer the random traffic toward hits.
  logic [PAGE_W-1:0] recent_pages[$];
  logic [PAGE_W-1:0] touched_pages[$];
  logic              page_touched[PAGE_SLOTS];

  int unsigned     error_count = 0;
  longint unsigned cycle_count = 0;

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Writes one TLB entry at the round-robin pointer and advances it.
  function automatic void fill_tlb_slot(logic [PAGE_W-1:0] page, logic [FRAME_W-1:0] frame);
    tlb_tag_q[tlb_next_slot]   = page;
    tlb_frame_q[tlb_next_slot] = frame;
    tlb_valid_q[tlb_next_slot] = 1'b1;
    tlb_next_slot = (tlb_next_slot + 1 >= TLB_SLOTS) ? 0 : tlb_next_slot + 1;
  endfunction

  // Computes the translation of one item and updates the state it touches.
  function automatic tlbptc_rsp_t translate_page(tlbptc_req_t req);
    tlbptc_rsp_t        rsp;
    logic [FRAME_W-1:0] frame;
    logic               found;
    int unsigned        pidx;
    int unsigned        i;
    rsp         = '0;
    rsp.outcome = OUT_NO_FRAME;
    frame       = '0;
    found       = 1'b0;
    pidx        = req.page_number % PAGE_SLOTS;
    // The lowest-indexed valid TLB match wins.
    for (i = 0; i < TLB_SLOTS; i++) begin
      if (!found && tlb_valid_q[i] && tlb_tag_q[i] == req.page_number) begin
        frame       = tlb_frame_q[i];
        rsp.outcome = OUT_TLB_HIT;
        found       = 1'b1;
      end
    end
    // A page table hit refills the TLB.
    if (!found && pt_present_q[pidx]) begin
      frame = pt_frame_q[pidx];
      fill_tlb_slot(req.page_number, frame);
      rsp.outcome = OUT_PT_HIT;
      found       = 1'b1;
    end
    // A page fault takes the lowest free frame, if any is left.
    for (i = 0; i < FRAME_SLOTS; i++) begin
      if (!found && !frame_taken_q[i]) begin
        frame_taken_q[i] = 1'b1;
        frame            = FRAME_W'(i);
        fill_tlb_slot(req.page_number, frame);
        pt_frame_q[pidx]   = frame;
        pt_present_q[pidx] = 1'b1;
        rsp.outcome        = OUT_FAULT;
        found              = 1'b1;
      end
    end
    if (found) begin
      rsp.frame_number     = frame;
      rsp.physical_address = {frame, req.offset};
    end
    return rsp;
  endfunction

  // Offers one item after an optional idle gap and records its translation once taken.
  task automatic send_item(logic [PAGE_W-1:0] page, logic [OFFSET_W-1:0] offset,
                           int unsigned gap);
    tlbptc_req_t req;
    int unsigned k;
    req.page_number = page;
    req.offset      = offset;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= req;
    do @(posedge clk_i); while (busy);
    expected_translations.push_back(translate_page(req));
    // Keep a short list of recently used pages and the set of all pages seen.
    if (!page_touched[page]) begin
      page_touched[page] = 1'b1;
      touched_pages.push_back(page);
    end
    k = 0;
    while (k < recent_pages.size()) begin
      if (recent_pages[k] == page) begin
        recent_pages.delete(k);
      end else begin
        k++;
      end
    end
    recent_pages.push_back(page);
    if (recent_pages.size() > RECENT_DEPTH) void'(recent_pages.pop_front());
  endtask

  // First touches of pages at the field extremes and two alternating patterns; each one faults.
  task automatic test_cold_faults();
    send_item(8'h00, 8'h00, $urandom_range(0, MAX_GAP));
    send_item(8'hFF, 8'hFF, $urandom_range(0, MAX_GAP));
    send_item(8'hAA, 8'h55, $urandom_range(0, MAX_GAP));
    send_item(8'h55, 8'hAA, $urandom_range(0, MAX_GAP));
  endtask

  // Pages just loaded must now hit in the TLB.
  task automatic test_tlb_hits();
    send_item(8'h00, 8'hFF, $urandom_range(0, MAX_GAP));
    send_item(8'hFF, 8'h00, $urandom_range(0, MAX_GAP));
  endtask

  // Enough faults to wrap the fill pointer, then revisit evicted pages so
  // that they come back from the page table.
  task automatic test_tlb_eviction();
    for (int unsigned p = 1; p <= 13; p++) begin
      send_item(PAGE_W'(p), OFFSET_W'($urandom_range(0, 255)), $urandom_range(0, MAX_GAP));
    end
    send_item(8'h00, 8'h80, $urandom_range(0, MAX_GAP));
    send_item(8'hFF, 8'h01, $urandom_range(0, MAX_GAP));
  endtask

  // Mixed traffic: mostly recent pages, then older pages, then any page.
  task automatic test_random_traffic();
    logic [PAGE_W-1:0] page;
    int unsigned       roll;
    int unsigned       gap;
    logic              no_idle;
    no_idle = 1'b0;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // Some stretches run back to back with no idle cycles.
      if (n % 64 == 0) no_idle = ($urandom_range(0, 2) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 55 && recent_pages.size() > 0) begin
        page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
      end else if (roll < 80 && touched_pages.size() > 0) begin
        page = touched_pages[$urandom_range(0, touched_pages.size() - 1)];
      end else begin
        page = PAGE_W'($urandom_range(0, 255));
      end
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      send_item(page, OFFSET_W'($urandom_range(0, 255)), gap);
    end
  endtask

  // Compare every result with the oldest outstanding translation.
  always @(posedge clk_i) begin
    tlbptc_rsp_t want;
    if (rsp_valid_o) begin
      if (expected_translations.size() == 0) begin
        $error("result with no item outstanding: %h", rsp_o);
        error_count++;
      end else begin
        want = expected_translations.pop_front();
        if (rsp_o.physical_address !== want.physical_address) begin
          $error("physical_address: expected %h, actual %h",
                 want.physical_address, rsp_o.physical_address);
          error_count++;
        end
        if (rsp_o.frame_number !== want.frame_number) begin
          $error("frame_number: expected %h, actual %h",
                 want.frame_number, rsp_o.frame_number);
          error_count++;
        end
        if (rsp_o.outcome !== want.outcome) begin
          $error("outcome: expected %0d, actual %0d", want.outcome, rsp_o.outcome);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tlb_page_table_translator_core regression: fail");
      $finish;
    end
  end

  // Reset, the test sequence, then drain and report.
  initial begin
    start  <= 1'b0;
    req_i  <= '0;
    rst_ni <= 1'b0;
    tlb_next_slot = 0;
    foreach (tlb_valid_q[i]) begin
      tlb_tag_q[i]   = '0;
      tlb_frame_q[i] = '0;
      tlb_valid_q[i] = 1'b0;
    end
    foreach (pt_present_q[i]) begin
      pt_frame_q[i]   = '0;
      pt_present_q[i] = 1'b0;
      page_touched[i] = 1'b0;
    end
    foreach (frame_taken_q[i]) frame_taken_q[i] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The block clears its page table after reset; send_item waits on busy.
    test_cold_faults();
    test_tlb_hits();
    test_tlb_eviction();
    test_random_traffic();
    start <= 1'b0;

    while (expected_translations.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tlb_page_table_translator_core regression: pass");
    end else begin
      $display("tlb_page_table_translator_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tlbptc_pkg.sv
design/tlbptc_cell.sv
design/tlbptc_page_table.sv
design/tlb_page_table_translator_core.sv
verif/tlb_page_table_translator_core_tb.sv
